// ===== design/tmk_pkg.sv =====
// Shared constants for the thin multipole kick unit: widths, register indexes, pole codes.
`timescale 1ns / 1ps

package tmk_pkg;

   // Default datapath width (Q1.30 positions and slopes at 32 bits)
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Width of every payload field on the ports
   localparam int FIELD_WIDTH = 32;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLE_ORDER = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KICK_GAIN  = 1'd1;

   // Pole order codes: power of z applied by the kick
   localparam logic [1:0] ORDER_Z5 = 2'd0;   // 12-pole
   localparam logic [1:0] ORDER_Z6 = 2'd1;   // 14-pole
   localparam logic [1:0] ORDER_Z7 = 2'd2;   // 16-pole
   localparam logic [1:0] ORDER_Z8 = 2'd3;   // 18-pole

endpackage

// ===== design/tmk_round_sat.sv =====
// Rounds a double-width signed product back to the datapath format and clamps it.
`timescale 1ns / 1ps

module tmk_round_sat #(
   parameter int DATA_WIDTH = tmk_pkg::DATA_WIDTH_DEFAULT,
   parameter int SHIFT      = tmk_pkg::DATA_WIDTH_DEFAULT - 2
) (
   input  logic signed [2*DATA_WIDTH-1:0] product,
   output logic signed [DATA_WIDTH-1:0]   result,
   output logic                           clamped
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int QW = PW - SHIFT;
   localparam logic [PW-1:0] HALF = PW'(1) << (SHIFT - 1);
   localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic [PW-1:0]           biased;
   logic [QW-1:0]           quot;
   logic [QW-DATA_WIDTH:0]  upper;
   logic                    in_range;

   // Round to nearest, ties away from zero: negative values get one less bias
   assign biased   = product + HALF - {{(PW-1){1'b0}}, product[PW-1]};
   assign quot     = biased[PW-1:SHIFT];

   // In range when all bits above the result's sign bit repeat it
   assign upper    = quot[QW-1:DATA_WIDTH-1];
   assign in_range = (&upper) | ~(|upper);
   assign clamped  = ~in_range;

   always_comb begin
      if (in_range) begin
         result = quot[DATA_WIDTH-1:0];
      end else if (quot[QW-1]) begin
         result = MIN_VAL;
      end else begin
         result = MAX_VAL;
      end
   end

endmodule

// ===== design/tmk_cmul.sv =====
// Two-stage pipelined complex multiply with rounding and saturation, or pass of operand a.
`timescale 1ns / 1ps

module tmk_cmul #(
   parameter int DATA_WIDTH = tmk_pkg::DATA_WIDTH_DEFAULT,
   parameter int SIDE_WIDTH = 6 * tmk_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // upstream
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         active,
   input  logic signed [DATA_WIDTH-1:0] a_re,
   input  logic signed [DATA_WIDTH-1:0] a_im,
   input  logic signed [DATA_WIDTH-1:0] b_re,
   input  logic signed [DATA_WIDTH-1:0] b_im,
   input  logic [SIDE_WIDTH-1:0]        in_side,
   input  logic                         in_flag,
   // downstream
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [DATA_WIDTH-1:0] out_re,
   output logic signed [DATA_WIDTH-1:0] out_im,
   output logic [SIDE_WIDTH-1:0]        out_side,
   output logic                         out_flag
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // stage 1: raw products
   logic                         v1_ff;
   logic signed [PW-1:0]         prod_rr_ff, prod_ii_ff, prod_ri_ff, prod_ir_ff;
   logic signed [DATA_WIDTH-1:0] pass_re_ff, pass_im_ff;
   logic                         active_ff;
   logic [SIDE_WIDTH-1:0]        side1_ff;
   logic                         flag1_ff;

   // stage 2: rounded and summed result
   logic                         v2_ff;
   logic signed [DATA_WIDTH-1:0] re_ff, im_ff;
   logic [SIDE_WIDTH-1:0]        side2_ff;
   logic                         flag2_ff;

   logic                         ready1, ready2;
   logic signed [DATA_WIDTH-1:0] q_rr, q_ii, q_ri, q_ir;
   logic                         c_rr, c_ii, c_ri, c_ir;
   logic [DATA_WIDTH:0]          diff, sum;
   logic                         re_sat, im_sat;
   logic signed [DATA_WIDTH-1:0] re_in, im_in;
   logic                         flag_in;

   // a stage takes a new item when empty or when its item moves on
   assign ready2   = ~v2_ff | out_ready;
   assign ready1   = ~v1_ff | ready2;
   assign in_ready = ready1;

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready1) begin
         prod_rr_ff <= PW'(a_re) * PW'(b_re);
         prod_ii_ff <= PW'(a_im) * PW'(b_im);
         prod_ri_ff <= PW'(a_re) * PW'(b_im);
         prod_ir_ff <= PW'(a_im) * PW'(b_re);
         pass_re_ff <= a_re;
         pass_im_ff <= a_im;
         active_ff  <= active;
         side1_ff   <= in_side;
         flag1_ff   <= in_flag;
      end
   end

   // round each product back to Q1.(D-2)
   tmk_round_sat #(.DATA_WIDTH(DATA_WIDTH), .SHIFT(DATA_WIDTH - 2)) u_rnd_rr (
      .product(prod_rr_ff), .result(q_rr), .clamped(c_rr));
   tmk_round_sat #(.DATA_WIDTH(DATA_WIDTH), .SHIFT(DATA_WIDTH - 2)) u_rnd_ii (
      .product(prod_ii_ff), .result(q_ii), .clamped(c_ii));
   tmk_round_sat #(.DATA_WIDTH(DATA_WIDTH), .SHIFT(DATA_WIDTH - 2)) u_rnd_ri (
      .product(prod_ri_ff), .result(q_ri), .clamped(c_ri));
   tmk_round_sat #(.DATA_WIDTH(DATA_WIDTH), .SHIFT(DATA_WIDTH - 2)) u_rnd_ir (
      .product(prod_ir_ff), .result(q_ir), .clamped(c_ir));

   // real part ac - bd, imaginary part ad + bc, both clamped
   assign diff   = {q_rr[DATA_WIDTH-1], q_rr} - {q_ii[DATA_WIDTH-1], q_ii};
   assign sum    = {q_ri[DATA_WIDTH-1], q_ri} + {q_ir[DATA_WIDTH-1], q_ir};
   assign re_sat = diff[DATA_WIDTH] ^ diff[DATA_WIDTH-1];
   assign im_sat = sum[DATA_WIDTH] ^ sum[DATA_WIDTH-1];

   always_comb begin
      if (!active_ff) begin
         re_in   = pass_re_ff;
         im_in   = pass_im_ff;
         flag_in = flag1_ff;
      end else begin
         if (re_sat) begin
            re_in = diff[DATA_WIDTH] ? MIN_VAL : MAX_VAL;
         end else begin
            re_in = diff[DATA_WIDTH-1:0];
         end
         if (im_sat) begin
            im_in = sum[DATA_WIDTH] ? MIN_VAL : MAX_VAL;
         end else begin
            im_in = sum[DATA_WIDTH-1:0];
         end
         flag_in = flag1_ff | c_rr | c_ii | c_ri | c_ir | re_sat | im_sat;
      end
   end

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff && ready2) begin
         re_ff    <= re_in;
         im_ff    <= im_in;
         side2_ff <= side1_ff;
         flag2_ff <= flag_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_side  = side2_ff;
   assign out_flag  = flag2_ff;

endmodule

// ===== design/thin_multipole_kick_unit.sv =====
// Top level of the thin multipole kick unit: power chain of z, gain kick and result register.
`timescale 1ns / 1ps

// Thin-lens multipole kick, one particle per item.
// Input channel req_*: position (pos_x, pos_y) and slopes (slope_x, slope_y), signed
// Q1.30 at the default width. Result channel rsp_*: kicked slopes and a flag that is
// set when any product, sum or result was clamped.
// Configuration: csr_write_en with csr_index selects pole_order (index 0) or
// kick_gain (index 1, signed Q8.23); write only while no item is in flight.
// A zero gain returns the slopes unchanged with the flag clear.
// Pipeline: ten register stages. Four complex-multiply steps of two register stages each
// (multiply, then round/clamp/add), then two stages for the gain multiply and the final
// saturating add; the last one is the result register. Throughput: one item per cycle
// while the receiver does not stall; every pole order takes the same path.
// Reset clears the pipeline valid bits, sets pole_order and kick_gain to zero.
// When the receiver stalls, the result holds and items close the gaps behind it;
// req_stall rises only once every stage holds an item.

module thin_multipole_kick_unit #(
   parameter int DATA_WIDTH = tmk_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [tmk_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tmk_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   // particle in
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [tmk_pkg::FIELD_WIDTH-1:0] req_pos_x,
   input  logic signed [tmk_pkg::FIELD_WIDTH-1:0] req_pos_y,
   input  logic signed [tmk_pkg::FIELD_WIDTH-1:0] req_slope_x,
   input  logic signed [tmk_pkg::FIELD_WIDTH-1:0] req_slope_y,
   // kicked particle out
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [tmk_pkg::FIELD_WIDTH-1:0] rsp_kicked_slope_x,
   output logic signed [tmk_pkg::FIELD_WIDTH-1:0] rsp_kicked_slope_y,
   output logic                                   rsp_saturated
);

   localparam int D      = DATA_WIDTH;
   localparam int PW     = 2 * DATA_WIDTH;
   localparam int SIDE_W = 6 * DATA_WIDTH;
   localparam logic [D-1:0] MAX_VAL = {1'b0, {(D-1){1'b1}}};
   localparam logic [D-1:0] MIN_VAL = {1'b1, {(D-1){1'b0}}};

   // configuration registers
   logic [1:0]          order_ff;
   logic signed [D-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= tmk_pkg::ORDER_Z5;
         gain_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tmk_pkg::CSR_POLE_ORDER: order_ff <= csr_write_data[1:0];
            tmk_pkg::CSR_KICK_GAIN:  gain_ff  <= D'(signed'(csr_write_data));
            default: ;
         endcase
      end
   end

   // input fields at datapath width
   logic signed [D-1:0] in_x, in_y, in_sx, in_sy;
   assign in_x  = D'(req_pos_x);
   assign in_y  = D'(req_pos_y);
   assign in_sx = D'(req_slope_x);
   assign in_sy = D'(req_slope_y);

   // side data: {x, y, slope_x, slope_y, z3_re, z3_im}
   logic                s1_valid, s2_valid, s3_valid, s4_valid;
   logic                s2_ready, s3_ready, s4_ready;
   logic signed [D-1:0] s1_re, s1_im, s2_re, s2_im, s3_re, s3_im, s4_re, s4_im;
   logic [SIDE_W-1:0]   s1_side, s2_side, s3_side, s4_side;
   logic                s1_flag, s2_flag, s3_flag, s4_flag;
   logic                c1_ready;
   logic [SIDE_W-1:0]   side_in, side3_in;

   logic signed [D-1:0] s1_x, s1_y, s2_x, s2_y, s3_z3re, s3_z3im;
   logic signed [D-1:0] op2_re, op2_im;
   logic signed [D-1:0] op3a_re, op3a_im, op3b_re, op3b_im;
   logic                sel_z4_first, step4_active;

   assign side_in  = {in_x, in_y, in_sx, in_sy, {(2*D){1'b0}}};
   assign s1_x     = s1_side[6*D-1:5*D];
   assign s1_y     = s1_side[5*D-1:4*D];
   assign s2_x     = s2_side[6*D-1:5*D];
   assign s2_y     = s2_side[5*D-1:4*D];
   assign s3_z3re  = s3_side[2*D-1:D];
   assign s3_z3im  = s3_side[D-1:0];
   assign side3_in = {s2_side[SIDE_W-1:2*D], s2_re, s2_im};

   assign req_stall = ~c1_ready;

   // step 1: z^2
   tmk_cmul #(.DATA_WIDTH(D), .SIDE_WIDTH(SIDE_W)) u_step1 (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(c1_ready), .active(1'b1),
      .a_re(in_x), .a_im(in_y), .b_re(in_x), .b_im(in_y),
      .in_side(side_in), .in_flag(1'b0),
      .out_valid(s1_valid), .out_ready(s2_ready),
      .out_re(s1_re), .out_im(s1_im), .out_side(s1_side), .out_flag(s1_flag));

   // step 2: z^4 = z^2*z^2 for z^5 and z^8, else z^3 = z*z^2
   assign sel_z4_first = (order_ff == tmk_pkg::ORDER_Z5) || (order_ff == tmk_pkg::ORDER_Z8);
   assign op2_re       = sel_z4_first ? s1_re : s1_x;
   assign op2_im       = sel_z4_first ? s1_im : s1_y;

   tmk_cmul #(.DATA_WIDTH(D), .SIDE_WIDTH(SIDE_W)) u_step2 (
      .clock(clock), .reset(reset),
      .in_valid(s1_valid), .in_ready(s2_ready), .active(1'b1),
      .a_re(op2_re), .a_im(op2_im), .b_re(s1_re), .b_im(s1_im),
      .in_side(s1_side), .in_flag(s1_flag),
      .out_valid(s2_valid), .out_ready(s3_ready),
      .out_re(s2_re), .out_im(s2_im), .out_side(s2_side), .out_flag(s2_flag));

   // step 3: z*z^4, z^3*z^3, z^3*z or z^4*z^4
   always_comb begin
      case (order_ff)
         tmk_pkg::ORDER_Z5: begin
            op3a_re = s2_x;  op3a_im = s2_y;  op3b_re = s2_re; op3b_im = s2_im;
         end
         tmk_pkg::ORDER_Z7: begin
            op3a_re = s2_re; op3a_im = s2_im; op3b_re = s2_x;  op3b_im = s2_y;
         end
         default: begin
            op3a_re = s2_re; op3a_im = s2_im; op3b_re = s2_re; op3b_im = s2_im;
         end
      endcase
   end

   tmk_cmul #(.DATA_WIDTH(D), .SIDE_WIDTH(SIDE_W)) u_step3 (
      .clock(clock), .reset(reset),
      .in_valid(s2_valid), .in_ready(s3_ready), .active(1'b1),
      .a_re(op3a_re), .a_im(op3a_im), .b_re(op3b_re), .b_im(op3b_im),
      .in_side(side3_in), .in_flag(s2_flag),
      .out_valid(s3_valid), .out_ready(s4_ready),
      .out_re(s3_re), .out_im(s3_im), .out_side(s3_side), .out_flag(s3_flag));

   // step 4: z^7 = z^3*z^4 for the 16-pole, otherwise the power passes through
   assign step4_active = (order_ff == tmk_pkg::ORDER_Z7);

   logic k1_ready;

   tmk_cmul #(.DATA_WIDTH(D), .SIDE_WIDTH(SIDE_W)) u_step4 (
      .clock(clock), .reset(reset),
      .in_valid(s3_valid), .in_ready(s4_ready), .active(step4_active),
      .a_re(s3_re), .a_im(s3_im), .b_re(s3_z3re), .b_im(s3_z3im),
      .in_side(s3_side), .in_flag(s3_flag),
      .out_valid(s4_valid), .out_ready(k1_ready),
      .out_re(s4_re), .out_im(s4_im), .out_side(s4_side), .out_flag(s4_flag));

   // kick stage 1: gain times the power of z
   logic                k1_valid_ff;
   logic signed [PW-1:0] kprod_x_ff, kprod_y_ff;
   logic signed [D-1:0] k1_sx_ff, k1_sy_ff;
   logic                k1_flag_ff;
   logic                k2_ready;

   assign k2_ready = ~rsp_valid | ~rsp_stall;
   assign k1_ready = ~k1_valid_ff | k2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_valid_ff <= 1'b0;
      end else if (k1_ready) begin
         k1_valid_ff <= s4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_valid && k1_ready) begin
         kprod_x_ff <= PW'(gain_ff) * PW'(s4_re);
         kprod_y_ff <= PW'(gain_ff) * PW'(s4_im);
         k1_sx_ff   <= s4_side[4*D-1:3*D];
         k1_sy_ff   <= s4_side[3*D-1:2*D];
         k1_flag_ff <= s4_flag;
      end
   end

   // kick stage 2: round the kick, apply it to the slopes
   logic signed [D-1:0] kick_x, kick_y;
   logic                kc_x, kc_y;
   logic [D:0]          nx, ny;
   logic                nx_sat, ny_sat;
   logic signed [D-1:0] out_x_in, out_y_in;
   logic                sat_in;

   tmk_round_sat #(.DATA_WIDTH(D), .SHIFT(D - 9)) u_rnd_kx (
      .product(kprod_x_ff), .result(kick_x), .clamped(kc_x));
   tmk_round_sat #(.DATA_WIDTH(D), .SHIFT(D - 9)) u_rnd_ky (
      .product(kprod_y_ff), .result(kick_y), .clamped(kc_y));

   assign nx     = {k1_sx_ff[D-1], k1_sx_ff} - {kick_x[D-1], kick_x};
   assign ny     = {k1_sy_ff[D-1], k1_sy_ff} + {kick_y[D-1], kick_y};
   assign nx_sat = nx[D] ^ nx[D-1];
   assign ny_sat = ny[D] ^ ny[D-1];

   always_comb begin
      if (gain_ff == '0) begin
         // no kick at all: slopes pass, nothing is flagged
         out_x_in = k1_sx_ff;
         out_y_in = k1_sy_ff;
         sat_in   = 1'b0;
      end else begin
         if (nx_sat) begin
            out_x_in = nx[D] ? MIN_VAL : MAX_VAL;
         end else begin
            out_x_in = nx[D-1:0];
         end
         if (ny_sat) begin
            out_y_in = ny[D] ? MIN_VAL : MAX_VAL;
         end else begin
            out_y_in = ny[D-1:0];
         end
         sat_in = k1_flag_ff | kc_x | kc_y | nx_sat | ny_sat;
      end
   end

   // result register
   logic                rsp_valid_ff;
   logic signed [D-1:0] rsp_x_ff, rsp_y_ff;
   logic                rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (k2_ready) begin
         rsp_valid_ff <= k1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (k1_valid_ff && k2_ready) begin
         rsp_x_ff   <= out_x_in;
         rsp_y_ff   <= out_y_in;
         rsp_sat_ff <= sat_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kicked_slope_x = tmk_pkg::FIELD_WIDTH'(rsp_x_ff);
   assign rsp_kicked_slope_y = tmk_pkg::FIELD_WIDTH'(rsp_y_ff);
   assign rsp_saturated      = rsp_sat_ff;

   // with the result register empty every stage can move, so input is open
   a_open_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall high with an empty result register");

   // a zero gain never flags saturation
   a_zero_gain_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (gain_ff == '0) |-> !rsp_saturated)
      else $error("saturated set with zero gain");

   // a new result only comes from an item held in the gain stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(k1_valid_ff))
      else $error("result appeared without an item in the gain stage");

   // an item leaving the gain stage lands in the result register
   a_gain_to_rsp: assert property (@(posedge clock) disable iff (reset)
      k1_valid_ff && k2_ready |=> rsp_valid)
      else $error("item lost between gain stage and result register");

endmodule
